### hdl/efra_pkg.sv
`default_nettype none

package efra_pkg;

  // Field widths
  localparam int unsigned IN_TIME_W  = 32;
  localparam int unsigned TIME_W     = 40;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ROOM_OUT_W = 4;
  localparam int unsigned CFG_W      = 5;

  // Limits and reset values
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CNT_RD,
    ST_WRITE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take the request, clear rooms on first_request
    logic scan_rd;  // read next room free time
    logic cnt_rd;   // pick the room, read its count
    logic commit;   // write back and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_issue;  // scan reads the last active room this cycle
    logic out_busy;    // result register full and not taken
  } sts_t;

endpackage : efra_pkg

`default_nettype wire

### hdl/efra_ifs.sv
`default_nettype none

// Request channel
interface efra_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic        first_request;

  modport source (output valid, output start_time, output end_time,
                  output first_request, input ready);
  modport sink   (input valid, input start_time, input end_time,
                  input first_request, output ready);
endinterface : efra_req_if

// Result channel
interface efra_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  assigned_room;
  logic [39:0] finish_time;
  logic        was_delayed;
  logic [3:0]  most_booked_room;

  modport source (output valid, output assigned_room, output finish_time,
                  output was_delayed, output most_booked_room, input ready);
  modport sink   (input valid, input assigned_room, input finish_time,
                  input was_delayed, input most_booked_room, output ready);
endinterface : efra_rsp_if

// Configuration write channel
interface efra_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] rooms_in_use;

  modport source (output valid, output rooms_in_use, input ready);
  modport sink   (input valid, input rooms_in_use, output ready);
endinterface : efra_cfg_if

`default_nettype wire

### hdl/efra_ctrl.sv
`default_nettype none

module efra_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire efra_pkg::sts_t sts_i,
  output efra_pkg::cmd_t     cmd_o
);
  import efra_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is folded into the trackers
        state_d = ST_CNT_RD;
      end
      ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : efra_ctrl

`default_nettype wire

### hdl/efra_dp.sv
`default_nettype none

module efra_dp #(
  parameter int unsigned MAX_ROOMS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_valid_i,
  input  wire logic [efra_pkg::CFG_W-1:0]      cfg_rooms_i,
  // request payload
  input  wire logic [efra_pkg::IN_TIME_W-1:0]  start_time_i,
  input  wire logic [efra_pkg::IN_TIME_W-1:0]  end_time_i,
  input  wire logic                            first_request_i,
  // control
  input  wire efra_pkg::cmd_t                  cmd_i,
  output efra_pkg::sts_t                       sts_o,
  // result
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [efra_pkg::ROOM_OUT_W-1:0]      assigned_room_o,
  output logic [efra_pkg::TIME_W-1:0]          finish_time_o,
  output logic                                 was_delayed_o,
  output logic [efra_pkg::ROOM_OUT_W-1:0]      most_booked_room_o
);
  import efra_pkg::*;

  localparam int unsigned RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROOMS + 1);

  // Configuration register
  logic [CFG_W-1:0] rooms_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      rooms_cfg_q <= cfg_rooms_i;
    end
  end

  // Active room count, clamped to 1..MAX_ROOMS
  logic [CW-1:0] n_act;

  always_comb begin
    if (rooms_cfg_q == '0) begin
      n_act = CW'(1);
    end else if (32'(rooms_cfg_q) > MAX_ROOMS) begin
      n_act = CW'(MAX_ROOMS);
    end else begin
      n_act = CW'(rooms_cfg_q);
    end
  end

  // Request registers
  logic [IN_TIME_W-1:0] start_q, end_q, dur_q;
  logic [CW-1:0]        n_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
      dur_q   <= (end_time_i > start_time_i) ? (end_time_i - start_time_i) : '0;
      n_q     <= n_act;
    end
  end

  // Scan counter and read pipeline tag
  logic [CW-1:0] scan_cnt_q;
  logic          rd_vld_q;
  logic [RW-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      rd_idx_q <= scan_cnt_q[RW-1:0];
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_cnt_q <= scan_cnt_q + CW'(1);
      end
    end
  end

  assign sts_o.last_issue = cmd_i.scan_rd && (scan_cnt_q == n_q - CW'(1));

  // Room memories; a room without its valid bit reads as cleared
  logic [TIME_W-1:0] free_mem [MAX_ROOMS];
  logic [CNT_W-1:0]  cnt_mem  [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] vld_q;
  logic [TIME_W-1:0] free_rd_q;
  logic [CNT_W-1:0]  cnt_rd_q;
  logic              free_rd_vld_q, cnt_rd_vld_q;

  logic [RW-1:0]     room_q;
  logic [TIME_W-1:0] finish_q;
  logic              delayed_q;
  logic [CNT_W-1:0]  cnt_new;
  logic [RW-1:0]     room_sel;

  // Memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      free_mem[room_q] <= finish_q;
      cnt_mem[room_q]  <= cnt_new;
    end
    if (cmd_i.scan_rd) begin
      free_rd_q <= free_mem[scan_cnt_q[RW-1:0]];
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[room_sel];
    end
  end

  // Valid bits: cleared at once by reset or a first request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      free_rd_vld_q <= 1'b0;
      cnt_rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_rd) begin
        free_rd_vld_q <= vld_q[scan_cnt_q[RW-1:0]];
      end
      if (cmd_i.cnt_rd) begin
        cnt_rd_vld_q <= vld_q[room_sel];
      end
      if (cmd_i.load && first_request_i) begin
        vld_q <= '0;
      end else if (cmd_i.commit) begin
        vld_q[room_q] <= 1'b1;
      end
    end
  end

  // Scan trackers: first free room, earliest freeing room
  logic [TIME_W-1:0] free_eff;
  logic              found_q;
  logic [RW-1:0]     found_idx_q;
  logic [TIME_W-1:0] min_q;
  logic [RW-1:0]     min_idx_q;

  assign free_eff = free_rd_vld_q ? free_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      found_idx_q <= '0;
      min_q       <= '0;
      min_idx_q   <= '0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!found_q && (free_eff <= TIME_W'(start_q))) begin
        found_q     <= 1'b1;
        found_idx_q <= rd_idx_q;
      end
      if ((rd_idx_q == '0) || (free_eff < min_q)) begin
        min_q     <= free_eff;
        min_idx_q <= rd_idx_q;
      end
    end
  end

  // Room choice and finish time
  logic [TIME_W:0]   delay_sum;
  logic [TIME_W-1:0] finish_sel;

  assign room_sel  = found_q ? found_idx_q : min_idx_q;
  assign delay_sum = {1'b0, min_q} + (TIME_W + 1)'(dur_q);

  always_comb begin
    if (found_q) begin
      finish_sel = TIME_W'(end_q);
    end else if (delay_sum[TIME_W]) begin
      finish_sel = TIME_MAX;
    end else begin
      finish_sel = delay_sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) begin
      room_q    <= room_sel;
      finish_q  <= finish_sel;
      delayed_q <= !found_q;
    end
  end

  // Saturating count update and most-booked record
  logic [CNT_W-1:0] cnt_old;
  logic [RW-1:0]    best_room_q;
  logic [CNT_W-1:0] best_cnt_q;

  assign cnt_old = cnt_rd_vld_q ? cnt_rd_q : '0;
  assign cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_room_q <= '0;
      best_cnt_q  <= '0;
    end else if (cmd_i.load && first_request_i) begin
      best_room_q <= '0;
      best_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      if ((cnt_new > best_cnt_q) ||
          ((cnt_new == best_cnt_q) && (room_q < best_room_q))) begin
        best_room_q <= room_q;
        best_cnt_q  <= cnt_new;
      end
    end
  end

  // Result register
  logic                  out_valid_q;
  logic [ROOM_OUT_W-1:0] out_room_q;
  logic [TIME_W-1:0]     out_finish_q;
  logic                  out_delayed_q;
  logic [ROOM_OUT_W-1:0] out_best_q;
  logic [RW-1:0]         best_next;

  assign best_next = ((cnt_new > best_cnt_q) ||
                      ((cnt_new == best_cnt_q) && (room_q < best_room_q)))
                     ? room_q : best_room_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_room_q    <= ROOM_OUT_W'(room_q);
      out_finish_q  <= finish_q;
      out_delayed_q <= delayed_q;
      out_best_q    <= ROOM_OUT_W'(best_next);
    end
  end

  assign sts_o.out_busy     = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign assigned_room_o    = out_room_q;
  assign finish_time_o      = out_finish_q;
  assign was_delayed_o      = out_delayed_q;
  assign most_booked_room_o = out_best_q;

`ifndef SYNTHESIS
  // scan never reads past the active rooms
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CW'(rd_idx_q) < n_q))
    else $error("scan index beyond active rooms");

  // a write never overruns a waiting result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("commit while result register is held");

  // a commit always shows a result next cycle
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("result missing after commit");

  // a room found free is reported without delay
  a_found_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_rd && found_q |=> !delayed_q && (finish_q == TIME_W'(end_q)))
    else $error("free room reported as delayed");
`endif

endmodule : efra_dp

`default_nettype wire

### hdl/earliest_free_room_allocator_top.sv
// Earliest-free room allocator. Each request (start, end, first_request) is
// given the lowest-numbered active room free by its start time, or else the
// room that frees earliest, in which case the meeting is postponed with its
// duration kept and was_delayed is set. Every request yields one result with
// the room, the finish time (saturating at 2^40-1) and the running most-booked
// room. After its transfer a request reads the free time of each of the n
// active rooms from the room memory, one room free time per cycle, followed
// by a drain, a count read and a write-back, which waits while the previous
// result is still held. The next request is taken once the write-back is done,
// even while that result still waits on the output. first_request
// clears all rooms in its transfer cycle; there is no clearing pass after
// reset. rooms_in_use may be written only while the block is idle.
`default_nettype none

module earliest_free_room_allocator_top #(
  parameter int unsigned MAX_ROOMS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  efra_cfg_if.sink    cfg_i,
  efra_req_if.sink    req_i,
  efra_rsp_if.source  rsp_o
);
  import efra_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  // Sequencer
  efra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Room memories, scan and result register
  efra_dp #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_rooms_i        (cfg_i.rooms_in_use),
    .start_time_i       (req_i.start_time),
    .end_time_i         (req_i.end_time),
    .first_request_i    (req_i.first_request),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .assigned_room_o    (rsp_o.assigned_room),
    .finish_time_o      (rsp_o.finish_time),
    .was_delayed_o      (rsp_o.was_delayed),
    .most_booked_room_o (rsp_o.most_booked_room)
  );

endmodule : earliest_free_room_allocator_top

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import efra_pkg::*;

  localparam int unsigned ROOMS      = 16;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned SETTLE_CYC = 24;

  // One expected result
  typedef struct {
    logic [ROOM_OUT_W-1:0] room;
    logic [TIME_W-1:0]     finish;
    logic                  delayed;
    logic [ROOM_OUT_W-1:0] busiest;
  } booking_t;

  // Scoreboard: room schedule predictor plus the queue of pending bookings
  class room_booking_board;
    logic [TIME_W-1:0] free_at   [ROOMS];
    logic [CNT_W-1:0]  bookings  [ROOMS];
    int unsigned       busiest_room;
    logic [CNT_W-1:0]  busiest_count;
    logic [CFG_W-1:0]  rooms_cfg;
    booking_t          pending_bookings[$];
    int unsigned       errors;

    function new();
      rooms_cfg = CFG_RESET;
      errors = 0;
      clear_rooms();
    endfunction

    function void clear_rooms();
      foreach (free_at[i]) begin
        free_at[i]  = '0;
        bookings[i] = '0;
      end
      busiest_room  = 0;
      busiest_count = '0;
    endfunction

    function void set_rooms(logic [CFG_W-1:0] v);
      rooms_cfg = v;
    endfunction

    // Predict the booking for one accepted request
    function void book_meeting(logic [IN_TIME_W-1:0] s, logic [IN_TIME_W-1:0] e,
                               logic first);
      int unsigned       n;
      int unsigned       room;
      bit                found;
      logic [TIME_W-1:0] dur;
      logic [TIME_W:0]   total;
      booking_t          b;
      n = 32'(rooms_cfg);
      if (n < 1) n = 1;
      if (n > ROOMS) n = ROOMS;
      if (first) clear_rooms();
      found = 0;
      room  = 0;
      // lowest active room already free at the start time
      for (int i = 0; i < n; i++) begin
        if (!found && free_at[i] <= TIME_W'(s)) begin
          room  = i;
          found = 1;
        end
      end
      if (found) begin
        b.finish  = TIME_W'(e);
        b.delayed = 1'b0;
      end else begin
        // postpone into the room that frees first
        dur = (e > s) ? TIME_W'(e - s) : '0;
        for (int i = 1; i < n; i++) begin
          if (free_at[i] < free_at[room]) room = i;
        end
        total     = {1'b0, free_at[room]} + {1'b0, dur};
        b.finish  = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
        b.delayed = 1'b1;
      end
      free_at[room] = b.finish;
      if (bookings[room] != CNT_MAX) bookings[room]++;
      if (bookings[room] > busiest_count ||
          (bookings[room] == busiest_count && room < busiest_room)) begin
        busiest_count = bookings[room];
        busiest_room  = room;
      end
      b.room    = ROOM_OUT_W'(room);
      b.busiest = ROOM_OUT_W'(busiest_room);
      pending_bookings.push_back(b);
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] exp_v,
                                logic [TIME_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one result transfer with the oldest pending booking
    function void check_booking(booking_t got);
      booking_t want;
      if (pending_bookings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual room %0d finish %0h",
                 $time, got.room, got.finish);
        return;
      end
      want = pending_bookings.pop_front();
      compare_field("assigned_room", TIME_W'(want.room), TIME_W'(got.room));
      compare_field("finish_time", want.finish, got.finish);
      compare_field("was_delayed", TIME_W'(want.delayed), TIME_W'(got.delayed));
      compare_field("most_booked_room", TIME_W'(want.busiest), TIME_W'(got.busiest));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  efra_cfg_if cfg_if();
  efra_req_if req_if();
  efra_rsp_if rsp_if();

  earliest_free_room_allocator_top #(.MAX_ROOMS(ROOMS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  room_booking_board board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles;
  int unsigned seq_left;
  logic [IN_TIME_W-1:0] cur_start;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random backpressure, check on every transfer
  always @(negedge clk_i) begin
    if (rst_ni) rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    booking_t got;
    if (rsp_if.valid && rsp_if.ready) begin
      got.room    = rsp_if.assigned_room;
      got.finish  = rsp_if.finish_time;
      got.delayed = rsp_if.was_delayed;
      got.busiest = rsp_if.most_booked_room;
      board.check_booking(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid left high, so the next call sets it exactly once.
  task automatic send_request(logic [IN_TIME_W-1:0] s, logic [IN_TIME_W-1:0] e,
                              logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.start_time    <= s;
    req_if.end_time      <= e;
    req_if.first_request <= first;
    do @(posedge clk_i); while (!req_if.ready);
    board.book_meeting(s, e, first);
    @(negedge clk_i);
  endtask

  // Hold requests until every pending booking has come back
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (board.pending_bookings.size() != 0) @(negedge clk_i);
  endtask

  // Room count write, only with the block idle
  task automatic write_rooms(logic [CFG_W-1:0] v);
    wait_for_results();
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.rooms_in_use <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.set_rooms(v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly ordered meeting sequences, with some noise
  task automatic random_request();
    logic [IN_TIME_W-1:0] s;
    logic [IN_TIME_W-1:0] e;
    logic [IN_TIME_W-1:0] dur;
    logic [IN_TIME_W:0]   nxt;
    logic                 first;
    int unsigned          pick;
    first = 1'b0;
    if ($urandom_range(0, 99) < 8) begin
      s     = $urandom;
      e     = $urandom;
      first = 1'($urandom_range(0, 1));
    end else begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(1, 40);
        first    = ($urandom_range(0, 99) < 80);
        pick     = $urandom_range(0, 3);
        if (pick == 0) cur_start = '0;
        else if (pick == 1) cur_start = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else cur_start = $urandom;
      end
      seq_left--;
      pick = $urandom_range(0, 99);
      if (pick < 30) nxt = {1'b0, cur_start};
      else if (pick < 97) nxt = {1'b0, cur_start} + $urandom_range(1, 12);
      else nxt = {1'b0, cur_start} + $urandom;
      cur_start = nxt[IN_TIME_W] ? '1 : nxt[IN_TIME_W-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 5) dur = '0;
      else if (pick < 90) dur = $urandom_range(1, 40);
      else dur = $urandom;
      s = cur_start;
      e = cur_start + dur;
    end
    send_request(s, e, first);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] rooms, int unsigned items);
    write_rooms(rooms);
    seq_left = 0;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) == 0) wait_for_results();
      random_request();
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    seq_left = 0;
    cur_start = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.rooms_in_use = '0;
    req_if.valid = 1'b0;
    req_if.start_time = '0;
    req_if.end_time = '0;
    req_if.first_request = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: two rooms, delays, zero and negative durations, extremes
    write_rooms(5'd2);
    send_request(32'd0, 32'd0, 1'b1);
    send_request(32'd0, 32'd10, 1'b0);
    send_request(32'd5, 32'd20, 1'b0);
    send_request(32'd6, 32'd8, 1'b0);
    send_request(32'd7, 32'd7, 1'b0);
    send_request(32'd3, 32'd4, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFF0, 32'd0, 1'b0);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd1, 32'd2, 1'b0);
    // zero rooms acts as one room
    write_rooms(5'd0);
    send_request(32'd100, 32'd200, 1'b1);
    send_request(32'd100, 32'd150, 1'b0);
    send_request(32'd300, 32'd301, 1'b0);
    // oversized room count acts as the full set; old rooms still count
    write_rooms(5'd31);
    send_request(32'd0, 32'd1, 1'b0);
    send_request(32'd0, 32'd1, 1'b0);
    send_request(32'd0, 32'd1, 1'b1);

    // Sender idles more lightly than the receiver
    send_idle_pct = 22;
    recv_idle_pct = 51;
    run_phase(5'd16, 120);
    run_phase(5'd1, 120);
    run_phase(CFG_W'($urandom_range(2, 15)), 120);

    // Roles swapped
    send_idle_pct = 51;
    recv_idle_pct = 22;
    run_phase(5'd0, 120);
    run_phase(5'd31, 120);
    run_phase(CFG_W'($urandom_range(0, 31)), 120);

    // No idling; single room pushed until finish times saturate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rooms(5'd1);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
    for (int i = 1; i <= 290; i++) send_request(i, 32'hFFFF_FFFF, 1'b0);
    run_phase(5'd16, 120);
    run_phase(5'd3, 120);

    // Drain and finish
    wait_for_results();
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (board.pending_bookings.size() != 0) begin
      board.errors++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, board.pending_bookings.size());
    end
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
